[src/calendar_to_unix_seconds_top_macros.svh]
// Assertion macros shared by the modules of the calendar converter.
// In a synthesis build the macros expand to nothing.
`ifndef CALENDAR_TO_UNIX_SECONDS_TOP_MACROS_SVH
`define CALENDAR_TO_UNIX_SECONDS_TOP_MACROS_SVH
`ifndef SYNTHESIS
`define CTU_ASSERT(lbl, clk, rst_n, prop) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
		else $error("calendar converter check failed");
`define CTU_ASSERT_ANY(lbl, clk, prop) \
	lbl: assert property (@(posedge clk) prop) \
		else $error("calendar converter check failed during reset");
`else
`define CTU_ASSERT(lbl, clk, rst_n, prop)
`define CTU_ASSERT_ANY(lbl, clk, prop)
`endif
`endif

[src/ctu_pkg.sv]
package ctu_pkg;

	localparam logic [13:0] YEAR_FIRST  = 14'd1970;
	localparam logic [13:0] YEAR_LAST   = 14'd9999;
	localparam logic [4:0]  HOURS_DAY   = 5'd24;
	localparam logic [5:0]  SIXTY       = 6'd60;
	localparam logic [3:0]  MONTH_FEB   = 4'd2;
	localparam logic [3:0]  MONTH_DEC   = 4'd12;
	localparam logic [4:0]  FEB_LEAP    = 5'd29;
	// Reciprocal of 25 scaled by 2^16, rounded up; exact for dividends below 4096.
	localparam logic [11:0] RECIP25     = 12'd2622;
	localparam logic [11:0] TWENTYFIVE  = 12'd25;
	// Leap days counted through 1969: 492 - 19 + 4.
	localparam logic [21:0] LEAPS_1969  = 22'd477;
	localparam logic [21:0] DAYS_YEAR   = 22'd365;
	localparam logic [16:0] SECS_HOUR   = 17'd3600;
	localparam logic [16:0] SECS_MINUTE = 17'd60;
	localparam logic [37:0] SECS_DAY    = 38'd86400;
	localparam logic [37:0] EPOCH_MAX   = 38'd253402300799;

	typedef struct packed {
		logic        base_ok;
		logic        y_div4;
		logic        y_div16;
		logic [11:0] y4;
		logic [9:0]  y16;
		logic [7:0]  q_y4;
		logic [7:0]  q_y16;
		logic [11:0] n4;
		logic [7:0]  q_n4;
		logic [7:0]  q_n16;
		logic [12:0] yoff;
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
	} ctu_s1_t;

	typedef struct packed {
		logic        ok;
		logic [21:0] days;
		logic [16:0] hms;
	} ctu_s3_t;

	// Quotient by 25 through the scaled reciprocal.
	function automatic logic [7:0] div25(input logic [11:0] x);
		logic [23:0] prod;
		prod = 24'(x) * 24'(RECIP25);
		return prod[23:16];
	endfunction

	function automatic logic [4:0] month_len(input logic [3:0] m);
		logic [4:0] len;
		unique case (m)
			4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
			4'd4, 4'd6, 4'd9, 4'd11:                     len = 5'd30;
			4'd2:                                        len = 5'd28;
			default:                                     len = 5'd0;
		endcase
		return len;
	endfunction

	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] start;
		unique case (m)
			4'd1:    start = 9'd0;
			4'd2:    start = 9'd31;
			4'd3:    start = 9'd59;
			4'd4:    start = 9'd90;
			4'd5:    start = 9'd120;
			4'd6:    start = 9'd151;
			4'd7:    start = 9'd181;
			4'd8:    start = 9'd212;
			4'd9:    start = 9'd243;
			4'd10:   start = 9'd273;
			4'd11:   start = 9'd304;
			4'd12:   start = 9'd334;
			default: start = 9'd0;
		endcase
		return start;
	endfunction

endpackage

[src/ctu_quot.sv]
module ctu_quot (
	input  logic                 clk,
	input  logic                 en,
	input  logic [13:0]          cal_year,
	input  logic [3:0]           cal_month,
	input  logic [4:0]           cal_day,
	input  logic [4:0]           cal_hour,
	input  logic [5:0]           cal_minute,
	input  logic [5:0]           cal_second,
	output ctu_pkg::ctu_s1_t     s1
);

	logic [13:0] y_m1;
	logic        base_ok;

	assign y_m1 = cal_year - 14'd1;

	assign base_ok = (cal_year >= ctu_pkg::YEAR_FIRST) && (cal_year <= ctu_pkg::YEAR_LAST)
		&& (cal_month != 4'd0) && (cal_month <= ctu_pkg::MONTH_DEC)
		&& (cal_hour < ctu_pkg::HOURS_DAY) && (cal_minute < ctu_pkg::SIXTY)
		&& (cal_second < ctu_pkg::SIXTY);

	// Quotients by 100 and 400 are taken as quotients by 25 of the year shifted by 2 and 4.
	always_ff @(posedge clk) begin
		if (en) begin
			s1.base_ok <= base_ok;
			s1.y_div4  <= (cal_year[1:0] == 2'd0);
			s1.y_div16 <= (cal_year[3:0] == 4'd0);
			s1.y4      <= cal_year[13:2];
			s1.y16     <= cal_year[13:4];
			s1.q_y4    <= ctu_pkg::div25(cal_year[13:2]);
			s1.q_y16   <= ctu_pkg::div25({2'b00, cal_year[13:4]});
			s1.n4      <= y_m1[13:2];
			s1.q_n4    <= ctu_pkg::div25(y_m1[13:2]);
			s1.q_n16   <= ctu_pkg::div25({2'b00, y_m1[13:4]});
			s1.yoff    <= 13'(cal_year - ctu_pkg::YEAR_FIRST);
			s1.month   <= cal_month;
			s1.day     <= cal_day;
			s1.hour    <= cal_hour;
			s1.minute  <= cal_minute;
			s1.second  <= cal_second;
		end
	end

endmodule

[src/ctu_days.sv]
module ctu_days (
	input  logic                 clk,
	input  logic                 en,
	input  ctu_pkg::ctu_s1_t     s1,
	output ctu_pkg::ctu_s3_t     s3
);

	logic        is_cent;
	logic        is_quad_cent;
	logic        leap;
	logic [4:0]  mlen;
	logic        day_ok;

	logic        ok_s2;
	logic [8:0]  yday_s2;
	logic [21:0] ydays_s2;
	logic [16:0] hms_s2;

	assign is_cent      = s1.y_div4 && ((12'(s1.q_y4) * ctu_pkg::TWENTYFIVE) == s1.y4);
	assign is_quad_cent = s1.y_div16
		&& ((12'(s1.q_y16) * ctu_pkg::TWENTYFIVE) == {2'b00, s1.y16});
	assign leap         = s1.y_div4 && (!is_cent || is_quad_cent);
	assign mlen         = (s1.month == ctu_pkg::MONTH_FEB && leap) ? ctu_pkg::FEB_LEAP
		: ctu_pkg::month_len(s1.month);
	assign day_ok       = (s1.day != 5'd0) && (s1.day <= mlen);

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s2    <= s1.base_ok && day_ok;
			yday_s2  <= ctu_pkg::month_start(s1.month)
				+ 9'((leap && s1.month > ctu_pkg::MONTH_FEB) ? 1 : 0)
				+ 9'(s1.day) - 9'd1;
			ydays_s2 <= 22'(s1.yoff) * ctu_pkg::DAYS_YEAR + 22'(s1.n4) - 22'(s1.q_n4)
				+ 22'(s1.q_n16) - ctu_pkg::LEAPS_1969;
			hms_s2   <= 17'(s1.hour) * ctu_pkg::SECS_HOUR
				+ 17'(s1.minute) * ctu_pkg::SECS_MINUTE + 17'(s1.second);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			s3.ok   <= ok_s2;
			s3.days <= ydays_s2 + 22'(yday_s2);
			s3.hms  <= hms_s2;
		end
	end

endmodule

[src/ctu_secs.sv]
module ctu_secs (
	input  logic                 clk,
	input  logic                 en,
	input  ctu_pkg::ctu_s3_t     s3,
	output logic                 conv_status,
	output logic [37:0]          epoch_seconds
);

	logic        ok_s4;
	logic [37:0] prod_s4;
	logic [16:0] hms_s4;

	always_ff @(posedge clk) begin
		if (en) begin
			ok_s4   <= s3.ok;
			prod_s4 <= 38'(s3.days) * ctu_pkg::SECS_DAY;
			hms_s4  <= s3.hms;
		end
	end

	// An invalid date leaves the count at zero.
	always_ff @(posedge clk) begin
		if (en) begin
			conv_status   <= !ok_s4;
			epoch_seconds <= ok_s4 ? (prod_s4 + 38'(hms_s4)) : 38'd0;
		end
	end

endmodule

[src/calendar_to_unix_seconds_top.sv]
// Throughput: one request per cycle; a result refused at the output freezes the whole pipeline.
// Reset (arst_n, asynchronous, active low) clears the stage valid bits only;
// the datapath registers hold whatever they had and are ignored until refilled.
`include "calendar_to_unix_seconds_top_macros.svh"

// Gregorian date and time of day to seconds since 1970-01-01 00:00:00.
//
// The pipeline has five register stages, each with a valid bit:
//   stage 1 (ctu_quot)  range checks on every field but the day, and the quotients by 25 of the
//                       year and of the year before, shifted by two and by four bits.
//                       These give the leap tests and the leap counts without a divider.
//   stage 2 (ctu_days)  leap year decision, month length and the day check, the day of
//                       the year, the days before the year and the seconds of the day.
//   stage 3 (ctu_days)  days since the epoch.
//   stage 4 (ctu_secs)  days multiplied by 86400.
//   stage 5 (ctu_secs)  seconds of the day added, or zero with status set when the
//                       date or time was invalid.
//
// All stages advance together whenever the last stage is empty or its result is being
// taken, so no request is lost or repeated under any pattern of stalls. The input is
// stalled only while a finished result is held waiting on the output.
module calendar_to_unix_seconds_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [13:0] cal_year,
	input  logic [3:0]  cal_month,
	input  logic [4:0]  cal_day,
	input  logic [4:0]  cal_hour,
	input  logic [5:0]  cal_minute,
	input  logic [5:0]  cal_second,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        conv_status,
	output logic [37:0] epoch_seconds
);

	ctu_pkg::ctu_s1_t s1;
	ctu_pkg::ctu_s3_t s3;

	logic en;
	logic v_s1;
	logic v_s2;
	logic v_s3;
	logic v_s4;
	logic v_s5;

	// The pipeline moves unless a result sits in the last stage and is refused.
	assign en        = !(v_s5 && out_stall);
	assign in_stall  = !en;
	assign out_valid = v_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else if (en) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	ctu_quot u_quot (
		.clk        (clk),
		.en         (en),
		.cal_year   (cal_year),
		.cal_month  (cal_month),
		.cal_day    (cal_day),
		.cal_hour   (cal_hour),
		.cal_minute (cal_minute),
		.cal_second (cal_second),
		.s1         (s1)
	);

	ctu_days u_days (
		.clk (clk),
		.en  (en),
		.s1  (s1),
		.s3  (s3)
	);

	ctu_secs u_secs (
		.clk           (clk),
		.en            (en),
		.s3            (s3),
		.conv_status   (conv_status),
		.epoch_seconds (epoch_seconds)
	);

	// A request that is accepted and then not stalled comes out on the output port.
	`CTU_ASSERT(a_latency, clk, arst_n, (in_valid && !in_stall) ##1 (!in_stall) [*4] |=> out_valid)
	// While stalled, no stage gains or loses a request.
	`CTU_ASSERT(a_hold, clk, arst_n, in_stall |=> $stable({v_s1, v_s2, v_s3, v_s4, v_s5}))
	// An invalid request carries a zero count.
	`CTU_ASSERT(a_invalid_zero, clk, arst_n, (out_valid && conv_status) |-> (epoch_seconds == 38'd0))
	// A converted date never goes past the end of year 9999.
	`CTU_ASSERT(a_range, clk, arst_n, (out_valid && !conv_status) |-> (epoch_seconds <= ctu_pkg::EPOCH_MAX))
	// Reset empties the pipeline at once.
	`CTU_ASSERT_ANY(a_reset_empty, clk, !arst_n |-> (!out_valid && !v_s1))

endmodule
